// File: design/assert_macros.svh
// Assertion macros shared by the 3x3 raster filter RTL.
// Compiled out when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RKF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rkf assertion failed");
`define RKF_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rkf forbidden condition seen");
`else
`define RKF_ASSERT(label, clk, rst_n, prop)
`define RKF_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: design/rkf_pkg.sv
// Shared types and constants of the 3x3 raster kernel filter.
// No dependencies; used by rkf_kernel and raster_3x3_kernel_filter.
`timescale 1ns / 1ps
package rkf_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_INDEX_W    = 2;
  localparam int MODE_W         = 2;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_RST        = 1024;

  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_AVERAGE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHARPEN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAPLACIAN = 2'd2;

  // sum of nine pixels fits 12 bits; signed kernels fit 13 bits
  localparam int SUM_W = 12;
  localparam int ACC_W = 13;

  // floor(s / 9) == (s * 3641) >> 15 for every s up to 9 * 255
  localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
  localparam int               DIV9_SHIFT = 15;

  localparam logic signed [ACC_W-1:0] SHARP_CENTER = 13'sd9;
  localparam logic signed [ACC_W-1:0] SHARP_UR     = 13'sd3;
  localparam logic signed [ACC_W-1:0] LAP_CENTER   = 13'sd4;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t pixel;
    logic drain;
  } in_req_t;

  typedef struct packed {
    pix_t filtered_pixel;
    logic frame_last;
  } out_req_t;

  // [row][col], row 0 is the row above, col 0 the left column
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } line_pair_t;

endpackage

// File: design/raster_3x3_kernel_filter.sv
// Top level of the streaming 3x3 raster kernel filter.
// Depends on rkf_pkg, rkf_ram, rkf_kernel and assert_macros.svh.
//
//   port group  direction  payload             handshake
//   in_*        input      rkf_pkg::in_req_t   in_valid / in_stall
//   out_*       output     rkf_pkg::out_req_t  out_valid / out_stall
//   cfg_*       input      11-bit write data   cfg_we, no wait
//
// One pixel per clock sustained while out_stall is low: the line memory takes
// one read and one write of the {upper, lower} row pair each cycle. A request
// passes the line read, window and output register stages in that order.
// Reset (rst_n low, synchronous) clears counters, window and valid flags; the
// line memory is not cleared. out_stall backs up through the stages one at a
// time, so in_stall rises only once the stage behind the line read is held.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module raster_3x3_kernel_filter #(
  parameter int MAX_WIDTH  = rkf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rkf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rkf_pkg::in_req_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rkf_pkg::out_req_t               out_data,
  input  logic                            cfg_we,
  input  logic [rkf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rkf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HRW = $clog2(MAX_HEIGHT);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int IRW = $clog2(MAX_HEIGHT + 2);
  localparam int LW  = 2 * rkf_pkg::PIX_W;

  localparam logic [WDW-1:0] WIDTH_RST =
    WDW'((rkf_pkg::DIM_RST > MAX_WIDTH) ? MAX_WIDTH : rkf_pkg::DIM_RST);
  localparam logic [HDW-1:0] HEIGHT_RST =
    HDW'((rkf_pkg::DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : rkf_pkg::DIM_RST);

  // configuration
  logic [rkf_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [WDW-1:0]             width_r, width_nxt;
  logic [HDW-1:0]             height_r, height_nxt;
  logic                       restart;

  // position counters
  logic [CW-1:0]  in_col_r, in_col_nxt;
  logic [IRW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;
  logic [HRW-1:0] out_row_r, out_row_nxt;

  // handshake and stage control
  logic in_accept, act, in_frame, emit, in_wrap, out_wrap, frame_end;
  logic s1_move, s2_ready, s2_move, out_accept;
  rkf_pkg::border_t border;

  // stage 1: line memory read
  logic                s1_v_r;
  rkf_pkg::pix_t       s1_x_r;
  logic [CW-1:0]       s1_col_r;
  logic                s1_emit_r;
  rkf_pkg::border_t    s1_border_r;
  logic                s1_last_r;
  logic                s1_fwd_r;
  rkf_pkg::line_pair_t s1_fwd_data_r;
  rkf_pkg::line_pair_t s1_line;
  rkf_pkg::line_pair_t ram_rdata;
  rkf_pkg::line_pair_t ram_wdata;

  // stage 2: window
  logic             s2_v_r;
  rkf_pkg::win_t    win_r;
  rkf_pkg::border_t s2_border_r;
  logic             s2_last_r;
  rkf_pkg::pix_t    kernel_out;

  // output register
  logic              out_v_r;
  rkf_pkg::out_req_t out_r;

  // ---------------------------------------------------------------- control
  assign s2_move    = s2_v_r && (!out_v_r || !out_stall);
  assign s2_ready   = !s2_v_r || s2_move;
  assign s1_move    = s1_v_r && s2_ready;
  assign in_stall   = s1_v_r && !s1_move;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_v_r && !out_stall;

  assign in_frame = in_row_r < IRW'(height_r);
  assign act      = in_accept && !(in_frame && in_data.drain);
  assign emit     = (in_row_r >= IRW'(2)) || (in_row_r == IRW'(1) && in_col_r != '0);
  assign in_wrap  = (WDW'(in_col_r) + WDW'(1)) >= width_r;
  assign out_wrap = (WDW'(out_col_r) + WDW'(1)) >= width_r;

  assign border.top    = out_row_r == '0;
  assign border.bottom = (HDW'(out_row_r) + HDW'(1)) >= height_r;
  assign border.left   = out_col_r == '0;
  assign border.right  = out_wrap;
  assign frame_end     = emit && border.bottom && border.right;

  // ---------------------------------------------------------------- config
  always_comb begin
    mode_nxt   = mode_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    restart    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        rkf_pkg::CFG_FILTER_MODE: begin
          mode_nxt = cfg_wdata[rkf_pkg::MODE_W-1:0];
        end
        rkf_pkg::CFG_IMAGE_WIDTH: begin
          restart = 1'b1;
          if (cfg_wdata == '0) begin
            width_nxt = WDW'(1);
          end else if (int'(cfg_wdata) > MAX_WIDTH) begin
            width_nxt = WDW'(MAX_WIDTH);
          end else begin
            width_nxt = WDW'(cfg_wdata);
          end
        end
        rkf_pkg::CFG_IMAGE_HEIGHT: begin
          restart = 1'b1;
          if (cfg_wdata == '0) begin
            height_nxt = HDW'(1);
          end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
            height_nxt = HDW'(MAX_HEIGHT);
          end else begin
            height_nxt = HDW'(cfg_wdata);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    priority if (restart || (act && frame_end)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (act) begin
      if (in_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + IRW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit) begin
        if (out_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HRW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= rkf_pkg::MODE_AVERAGE;
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------- line memory
  // entry holds the pixel two rows up and one row up; read when act is high,
  // written back as stage 1 moves on, with the row moved up by one
  assign s1_line         = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign ram_wdata.upper = s1_line.lower;
  assign ram_wdata.lower = s1_x_r;

  rkf_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (act),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (act) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      s1_x_r        <= in_frame ? in_data.pixel : '0;
      s1_col_r      <= in_col_r;
      s1_emit_r     <= emit;
      s1_border_r   <= border;
      s1_last_r     <= frame_end;
      // same entry written back this edge: take the new pair
      s1_fwd_r      <= s1_move && (s1_col_r == in_col_r);
      s1_fwd_data_r <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      win_r  <= '0;
    end else begin
      if (s1_move) begin
        s2_v_r <= s1_emit_r;
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[0][2] <= s1_line.upper;
        win_r[1][2] <= s1_line.lower;
        win_r[2][2] <= s1_x_r;
      end else if (s2_move) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_border_r <= s1_border_r;
      s2_last_r   <= s1_last_r;
    end
  end

  rkf_kernel u_kernel (
    .win    (win_r),
    .border (s2_border_r),
    .mode   (mode_r),
    .result (kernel_out)
  );

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_move) begin
      out_v_r <= 1'b1;
    end else if (out_accept) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_r.filtered_pixel <= kernel_out;
      out_r.frame_last     <= s2_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- checks
  `RKF_ASSERT(a_in_col_range, clk, rst_n, WDW'(in_col_r) < width_r)
  `RKF_ASSERT_NEVER(a_out_row_range, clk, rst_n, HDW'(out_row_r) >= height_r)
  `RKF_ASSERT(a_in_row_range, clk, rst_n, in_row_r <= (IRW'(height_r) + IRW'(1)))
  `RKF_ASSERT(a_frame_restart, clk, rst_n, (act && frame_end) |=>
    (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))

endmodule

// File: design/rkf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module rkf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/rkf_kernel.sv
// 3x3 stencil arithmetic: border masking, kernel select, divide by 9, clamp.
// Depends on rkf_pkg.
`timescale 1ns / 1ps
module rkf_kernel (
  input  rkf_pkg::win_t                win,
  input  rkf_pkg::border_t             border,
  input  logic [rkf_pkg::MODE_W-1:0]   mode,
  output rkf_pkg::pix_t                result
);

  localparam int SW = rkf_pkg::SUM_W;
  localparam int AW = rkf_pkg::ACC_W;
  localparam int PW = rkf_pkg::PIX_W;

  rkf_pkg::win_t            tap;
  logic [2:0]               row_kill;
  logic [2:0]               col_kill;
  logic [SW-1:0]            sum;
  logic [2*SW-1:0]          prod;
  rkf_pkg::pix_t            avg;
  logic signed [AW-1:0]     cc, uu, dd, ll, rr;
  logic signed [AW-1:0]     acc;
  rkf_pkg::pix_t            clamped;

  always_comb begin
    row_kill = {border.bottom, 1'b0, border.top};
    col_kill = {border.right, 1'b0, border.left};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap[i][j] = (row_kill[i] || col_kill[j]) ? '0 : win[i][j];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = sum + SW'(tap[i][j]);
      end
    end
    prod = (2*SW)'(sum) * (2*SW)'(rkf_pkg::DIV9_MUL);
    avg  = prod[rkf_pkg::DIV9_SHIFT +: PW];
  end

  assign cc = $signed({{(AW-PW){1'b0}}, tap[1][1]});
  assign uu = $signed({{(AW-PW){1'b0}}, tap[0][1]});
  assign dd = $signed({{(AW-PW){1'b0}}, tap[2][1]});
  assign ll = $signed({{(AW-PW){1'b0}}, tap[1][0]});
  assign rr = $signed({{(AW-PW){1'b0}}, tap[1][2]});

  always_comb begin
    unique case (mode)
      rkf_pkg::MODE_SHARPEN: begin
        acc = rkf_pkg::SHARP_CENTER * cc - rkf_pkg::SHARP_UR * uu
              - rkf_pkg::SHARP_UR * rr - ll - dd;
      end
      rkf_pkg::MODE_LAPLACIAN: begin
        acc = rkf_pkg::LAP_CENTER * cc - uu - dd - ll - rr;
      end
      default: begin
        acc = '0;
      end
    endcase
  end

  always_comb begin
    if (acc[AW-1]) begin
      clamped = '0;
    end else if (|acc[AW-2:PW]) begin
      clamped = '1;
    end else begin
      clamped = acc[PW-1:0];
    end
  end

  assign result = (mode == rkf_pkg::MODE_SHARPEN || mode == rkf_pkg::MODE_LAPLACIAN)
                  ? clamped : avg;

endmodule
